// ===== rtl/core/mgs_pkg.sv =====
package mgs_pkg;

   // field and register widths
   localparam int RAND_W   = 16;
   localparam int WEIGHT_W = 12;
   localparam int SWEEP_W  = 16;
   localparam int PARENT_W = 9;
   localparam int PROB_W   = 16;
   localparam int ROW_W    = 3;
   localparam int TALLY_W  = 16;

   // configuration port
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   localparam logic [1:0] REG_PARENT_BITS    = 2'd0;
   localparam logic [1:0] REG_WEIGHT_PARENT  = 2'd1;
   localparam logic [1:0] REG_WEIGHT_TRANS   = 2'd2;
   localparam logic [1:0] REG_BURN_IN_SWEEPS = 2'd3;

   localparam logic [PARENT_W-1:0] PARENT_RESET  = 9'd34;
   localparam logic [WEIGHT_W-1:0] WPARENT_RESET = 12'd384;
   localparam logic [WEIGHT_W-1:0] WTRANS_RESET  = 12'd307;
   localparam logic [SWEEP_W-1:0]  BURN_RESET    = 16'd5000;

   // logistic table: 256 entries over x = -8 .. +7.9375 in steps of 1/16
   localparam int TAB_IDX_W = 8;
   localparam int TAB_DEPTH = 256;
   localparam int TAB_MID   = 128;

   localparam logic [63:0] EXP_STEP_Q20 = 64'd1116203;
   localparam logic [63:0] ONE_Q32      = 64'h0000_0001_0000_0000;
   localparam logic [63:0] ONE_Q48      = 64'h0001_0000_0000_0000;
   localparam logic [63:0] HALF_Q20     = 64'h0000_0000_0008_0000;

   // e^(m/16) in Q32, by repeated multiply with rounding
   function automatic logic [63:0] exp_q32(input int m);
      logic [63:0] e;
      e = ONE_Q32;
      for (int i = 1; i <= m; i++) begin
         e = (e * EXP_STEP_Q20 + HALF_Q20) >> 20;
      end
      return e;
   endfunction

endpackage

// ===== rtl/core/mgs_ram.sv =====
module mgs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 9
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/mgs_logistic.sv =====
module mgs_logistic (
   input  logic [mgs_pkg::TAB_IDX_W-1:0] index,
   output logic [mgs_pkg::PROB_W-1:0]    prob
);

   import mgs_pkg::*;

   logic [PROB_W-1:0] tab [TAB_DEPTH];

   // constant table, each entry evaluated at elaboration
   for (genvar k = 0; k < TAB_DEPTH; k++) begin : g_ent
      localparam int          M        = (k >= TAB_MID) ? (k - TAB_MID) : (TAB_MID - k);
      localparam logic [63:0] E        = exp_q32(M);
      localparam logic [63:0] DEN      = E + ONE_Q32;
      localparam logic [63:0] NUM      = (k >= TAB_MID) ? (E << 16) : ONE_Q48;
      localparam logic [63:0] PROB_RAW = (NUM + DEN / 2) / DEN;
      localparam logic [PROB_W-1:0] PROB_SAT =
         (PROB_RAW > 64'd65535) ? 16'hFFFF : PROB_RAW[PROB_W-1:0];
      assign tab[k] = PROB_SAT;
   end

   assign prob = tab[index];

endmodule

// ===== rtl/core/mgs_energy.sv =====
module mgs_energy #(
   parameter int PERSONS = 3
) (
   input  logic [PERSONS*PERSONS-1:0]      anc,
   input  logic [$clog2(PERSONS)-1:0]      row,
   input  logic [$clog2(PERSONS)-1:0]      col,
   input  logic                            parent_bit,
   input  logic [mgs_pkg::WEIGHT_W-1:0]    weight_parent,
   input  logic [mgs_pkg::WEIGHT_W-1:0]    weight_trans,
   output logic [mgs_pkg::TAB_IDX_W-1:0]   tab_idx
);

   import mgs_pkg::*;

   localparam int NVARS = PERSONS * PERSONS;
   localparam int IW    = $clog2(NVARS);
   localparam int CNT_W = $clog2(PERSONS) + 2;
   localparam int D_W   = WEIGHT_W + CNT_W + 2;

   logic [CNT_W-1:0]        pos_cnt;
   logic [CNT_W-1:0]        neg_cnt;
   logic signed [CNT_W-1:0] cnt;
   logic signed [D_W-1:0]   prod;
   logic signed [D_W-1:0]   diff;
   logic [11:0]             clamped;

   // change in satisfied transitivity groundings when A(row,col) goes 0 -> 1
   always_comb begin
      logic [IW-1:0] i_rb;
      logic [IW-1:0] i_bc;
      logic [IW-1:0] i_cb;
      logic [IW-1:0] i_br;
      logic          a_rb;
      logic          a_bc;
      logic          a_cb;
      logic          a_br;
      pos_cnt = '0;
      neg_cnt = '0;
      for (int b = 0; b < PERSONS; b++) begin
         i_rb = IW'(row * PERSONS + b);
         i_bc = IW'(b * PERSONS + col);
         i_cb = IW'(col * PERSONS + b);
         i_br = IW'(b * PERSONS + row);
         a_rb = anc[i_rb];
         a_bc = anc[i_bc];
         a_cb = anc[i_cb];
         a_br = anc[i_br];
         if (b != int'(row) && b != int'(col)) begin
            pos_cnt = pos_cnt + CNT_W'(a_rb & a_bc);
            neg_cnt = neg_cnt + CNT_W'(a_cb & ~a_rb) + CNT_W'(a_br & ~a_bc);
         end
      end
   end

   assign cnt  = signed'(pos_cnt - neg_cnt);
   assign prod = D_W'(signed'({1'b0, weight_trans})) * D_W'(cnt);
   assign diff = prod + (parent_bit ? D_W'(signed'({1'b0, weight_parent})) : D_W'(0));

   // saturate to signed Q4.8
   always_comb begin
      priority if (diff > 2047) begin
         clamped = 12'h7FF;
      end else if (diff < -2048) begin
         clamped = 12'h800;
      end else begin
         clamped = diff[11:0];
      end
   end

   // (clamped + 2048) >> 4
   assign tab_idx = {~clamped[11], clamped[10:4]};

endmodule

// ===== rtl/core/mln_gibbs_sampler_unit.sv =====
// Gibbs sampler over the off-diagonal ancestor bits of PERSONS people.
// Input channel (req_): one beat carries a 16-bit uniform random word; each
// beat resamples the next ancestor bit in sweep order (row by row, columns in
// order, diagonal skipped).
// Result channel (rsp_): one beat per input beat, in order, with the updated
// variable, its new value, an end-of-sweep flag, the burn-in status and the
// variable's tally after the update.
// A beat accepted on req_ is held in the input register and then in the result
// register, which drives rsp_. Throughput is one beat per cycle while rsp_stall
// is low; the state update, logistic lookup and tally update are all
// combinational between the input register and the result register.
// Tallies sit in a small RAM read when a beat is accepted; per-entry valid
// flops make an unwritten tally read as zero, so no clearing pass is needed.
// Reset (synchronous) restores the registers to their defaults, clears the
// ancestor bits, sweep counter and tallies, and sets the cursor to the first
// variable; req_ is taken the cycle after reset drops.
// When the receiver holds rsp_stall, the result register keeps its beat and
// one more beat may sit in the input register; req_stall rises after that.
// Registers (APB, 32-bit, byte address 4*i): parent bits, parent weight,
// transitivity weight, burn-in sweeps. Write only while the block is idle.
module mln_gibbs_sampler_unit #(
   parameter int PERSONS    = 3,
   parameter int TALLY_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mgs_pkg::RAND_W-1:0]    req_rand_value,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mgs_pkg::ROW_W-1:0]     rsp_var_row,
   output logic [mgs_pkg::ROW_W-1:0]     rsp_var_col,
   output logic                          rsp_new_value,
   output logic                          rsp_end_of_sweep,
   output logic                          rsp_sampling_active,
   output logic [mgs_pkg::TALLY_W-1:0]   rsp_tally,
   // configuration
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mgs_pkg::ADDR_W-1:0]    paddr,
   input  logic [mgs_pkg::DATA_W-1:0]    pwdata,
   output logic [mgs_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);

   import mgs_pkg::*;

   localparam int NVARS = PERSONS * PERSONS;
   localparam int IW    = $clog2(NVARS);
   localparam int RW    = $clog2(PERSONS);

   // configuration registers
   logic [NVARS-1:0]    parent_ff;
   logic [WEIGHT_W-1:0] wparent_ff;
   logic [WEIGHT_W-1:0] wtrans_ff;
   logic [SWEEP_W-1:0]  burn_ff;
   logic                csr_we;
   logic [NVARS+8:0]    parent_wr_ext;
   logic [NVARS+8:0]    parent_rst_ext;

   // fetch cursor
   logic [RW-1:0] fetch_row_ff;
   logic [RW-1:0] fetch_col_ff;
   logic [RW-1:0] fetch_row_in;
   logic [RW-1:0] fetch_col_in;
   logic          fetch_eos;
   logic [IW-1:0] fetch_idx;

   // input register
   logic              in_valid_ff;
   logic [RAND_W-1:0] in_rand_ff;
   logic [RW-1:0]     in_row_ff;
   logic [RW-1:0]     in_col_ff;
   logic [IW-1:0]     in_idx_ff;
   logic              in_eos_ff;
   logic              in_tvalid_ff;

   // sampler state
   logic [NVARS-1:0]   anc_ff;
   logic [NVARS-1:0]   anc_in;
   logic [SWEEP_W-1:0] sweep_count_ff;
   logic [SWEEP_W-1:0] sweep_count_in;
   logic [NVARS-1:0]   tally_vld_ff;

   // result register
   logic                rsp_valid_ff;
   logic [ROW_W-1:0]    rsp_var_row_ff;
   logic [ROW_W-1:0]    rsp_var_col_ff;
   logic                rsp_new_value_ff;
   logic                rsp_end_of_sweep_ff;
   logic                rsp_sampling_active_ff;
   logic [TALLY_W-1:0]  rsp_tally_ff;

   // datapath
   logic                  req_fire;
   logic                  advance;
   logic                  exec;
   logic [TAB_IDX_W-1:0]  tab_idx;
   logic [PROB_W-1:0]     prob;
   logic                  new_bit;
   logic                  active;
   logic [TALLY_BITS-1:0] ram_rd;
   logic [TALLY_BITS-1:0] cur_tally;
   logic [TALLY_BITS-1:0] tally_in;

   // ---------------------------------------------------------------- csr
   assign pready         = 1'b1;
   assign csr_we         = psel && penable && pwrite;
   assign parent_wr_ext  = {NVARS'(0), pwdata[PARENT_W-1:0]};
   assign parent_rst_ext = {NVARS'(0), PARENT_RESET};

   always_ff @(posedge clock) begin
      if (reset) begin
         parent_ff  <= parent_rst_ext[NVARS-1:0];
         wparent_ff <= WPARENT_RESET;
         wtrans_ff  <= WTRANS_RESET;
         burn_ff    <= BURN_RESET;
      end else if (csr_we) begin
         unique case (paddr[3:2])
            REG_PARENT_BITS:    parent_ff  <= parent_wr_ext[NVARS-1:0];
            REG_WEIGHT_PARENT:  wparent_ff <= pwdata[WEIGHT_W-1:0];
            REG_WEIGHT_TRANS:   wtrans_ff  <= pwdata[WEIGHT_W-1:0];
            REG_BURN_IN_SWEEPS: burn_ff    <= pwdata[SWEEP_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_PARENT_BITS:    prdata = DATA_W'(parent_ff[PARENT_W-1:0]);
         REG_WEIGHT_PARENT:  prdata = DATA_W'(wparent_ff);
         REG_WEIGHT_TRANS:   prdata = DATA_W'(wtrans_ff);
         REG_BURN_IN_SWEEPS: prdata = DATA_W'(burn_ff);
      endcase
   end

   // ---------------------------------------------------------- handshake
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign exec      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_fire  = req_valid && !req_stall;

   // ------------------------------------------------------- fetch cursor
   assign fetch_idx = IW'(fetch_row_ff * PERSONS + fetch_col_ff);

   always_comb begin
      logic [RW:0] c_next;
      logic [RW:0] r_next;
      c_next       = {1'b0, fetch_col_ff} + 1'b1;
      r_next       = {1'b0, fetch_row_ff} + 1'b1;
      fetch_eos    = 1'b0;
      fetch_row_in = fetch_row_ff;
      fetch_col_in = c_next[RW-1:0];
      if (c_next == {1'b0, fetch_row_ff}) begin
         c_next       = c_next + 1'b1;
         fetch_col_in = c_next[RW-1:0];
      end
      if (c_next >= (RW+1)'(PERSONS)) begin
         if (r_next >= (RW+1)'(PERSONS)) begin
            // last variable of the sweep
            fetch_row_in = '0;
            fetch_col_in = RW'(1);
            fetch_eos    = 1'b1;
         end else begin
            fetch_row_in = r_next[RW-1:0];
            fetch_col_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fetch_row_ff <= '0;
         fetch_col_ff <= RW'(1);
         in_valid_ff  <= 1'b0;
      end else begin
         if (req_fire) begin
            fetch_row_ff <= fetch_row_in;
            fetch_col_ff <= fetch_col_in;
         end
         if (req_fire) begin
            in_valid_ff <= 1'b1;
         end else if (exec) begin
            in_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_rand_ff   <= req_rand_value;
         in_row_ff    <= fetch_row_ff;
         in_col_ff    <= fetch_col_ff;
         in_idx_ff    <= fetch_idx;
         in_eos_ff    <= fetch_eos;
         in_tvalid_ff <= tally_vld_ff[fetch_idx];
      end
   end

   // ----------------------------------------------------------- tallies
   mgs_ram #(
      .WIDTH (TALLY_BITS),
      .DEPTH (NVARS)
   ) u_tally_ram (
      .clock   (clock),
      .wr_en   (exec),
      .wr_addr (in_idx_ff),
      .wr_data (tally_in),
      .rd_en   (req_fire),
      .rd_addr (fetch_idx),
      .rd_data (ram_rd)
   );

   assign cur_tally = in_tvalid_ff ? ram_rd : '0;
   assign active    = sweep_count_ff >= burn_ff;
   assign tally_in  = (active && new_bit && cur_tally != '1) ? cur_tally + 1'b1 : cur_tally;

   // ------------------------------------------------------------ sampler
   mgs_energy #(
      .PERSONS (PERSONS)
   ) u_energy (
      .anc           (anc_ff),
      .row           (in_row_ff),
      .col           (in_col_ff),
      .parent_bit    (parent_ff[in_idx_ff]),
      .weight_parent (wparent_ff),
      .weight_trans  (wtrans_ff),
      .tab_idx       (tab_idx)
   );

   mgs_logistic u_logistic (
      .index (tab_idx),
      .prob  (prob)
   );

   assign new_bit = in_rand_ff < prob;

   always_comb begin
      anc_in         = anc_ff;
      anc_in[in_idx_ff] = new_bit;
      sweep_count_in = sweep_count_ff;
      if (in_eos_ff && sweep_count_ff != '1) begin
         sweep_count_in = sweep_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         anc_ff         <= '0;
         sweep_count_ff <= '0;
         tally_vld_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (exec) begin
            anc_ff                  <= anc_in;
            sweep_count_ff          <= sweep_count_in;
            tally_vld_ff[in_idx_ff] <= 1'b1;
         end
         if (exec) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_var_row_ff         <= ROW_W'(in_row_ff);
         rsp_var_col_ff         <= ROW_W'(in_col_ff);
         rsp_new_value_ff       <= new_bit;
         rsp_end_of_sweep_ff    <= in_eos_ff;
         rsp_sampling_active_ff <= active;
         rsp_tally_ff           <= TALLY_W'(tally_in);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_var_row         = rsp_var_row_ff;
   assign rsp_var_col         = rsp_var_col_ff;
   assign rsp_new_value       = rsp_new_value_ff;
   assign rsp_end_of_sweep    = rsp_end_of_sweep_ff;
   assign rsp_sampling_active = rsp_sampling_active_ff;
   assign rsp_tally           = rsp_tally_ff;

   // --------------------------------------------------------- assertions
   a_cursor_off_diag: assert property (@(posedge clock) disable iff (reset)
      fetch_row_ff != fetch_col_ff)
      else $error("fetch cursor on the diagonal");

   a_eos_last_var: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_eos_ff |->
         in_row_ff == RW'(PERSONS - 1) && in_col_ff == RW'(PERSONS - 2))
      else $error("end of sweep flagged on a variable that is not last");

   a_sweep_monotone: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> sweep_count_ff >= $past(sweep_count_ff))
      else $error("sweep counter went backwards");

   a_tally_frozen_burn_in: assert property (@(posedge clock) disable iff (reset)
      exec && !active |-> tally_in == cur_tally)
      else $error("tally changed during burn-in");

   a_no_stall_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> !req_stall)
      else $error("input stalled with an empty result register");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import mgs_pkg::*;

   localparam int PERSONS = 3;
   localparam int NVARS = PERSONS * PERSONS;
   localparam int QUIET_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_WORDS = 235;
   localparam int NUM_PHASES = 8;
   localparam logic [63:0] GROWTH_Q20 = 64'd1116203;

   typedef struct packed {
      logic [ROW_W-1:0]   row;
      logic [ROW_W-1:0]   col;
      logic               new_bit;
      logic               sweep_end;
      logic               active;
      logic [TALLY_W-1:0] tally;
   } sample_type;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [RAND_W-1:0]   req_rand_value = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [ROW_W-1:0]    rsp_var_row;
   logic [ROW_W-1:0]    rsp_var_col;
   logic                rsp_new_value;
   logic                rsp_end_of_sweep;
   logic                rsp_sampling_active;
   logic [TALLY_W-1:0]  rsp_tally;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [DATA_W-1:0]   pwdata = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   // predictor state and shadow registers
   logic [PROB_W-1:0]   logistic_lut [0:TAB_DEPTH-1];
   logic [NVARS-1:0]    anc_bits;
   int                  cur_row;
   int                  cur_col;
   logic [SWEEP_W-1:0]  sweeps_done;
   logic [TALLY_W-1:0]  tallies [0:NVARS-1];
   logic [PARENT_W-1:0] cfg_parent;
   logic [WEIGHT_W-1:0] cfg_w_parent;
   logic [WEIGHT_W-1:0] cfg_w_trans;
   logic [SWEEP_W-1:0]  cfg_burn_in;

   sample_type pending_samples[$];

   int mismatch_count = 0;
   int words_sent = 0;
   int samples_checked = 0;
   int ones_sampled = 0;
   int tally_bumps = 0;
   int sweeps_ended = 0;
   int reg_writes = 0;
   int quiet_cycles = 0;

   mln_gibbs_sampler_unit DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rand_value      (req_rand_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_var_row         (rsp_var_row),
      .rsp_var_col         (rsp_var_col),
      .rsp_new_value       (rsp_new_value),
      .rsp_end_of_sweep    (rsp_end_of_sweep),
      .rsp_sampling_active (rsp_sampling_active),
      .rsp_tally           (rsp_tally),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic void build_logistic_lut();
      logic [63:0] pow_e [0:TAB_MID];
      logic [63:0] e, den, num, p;
      int m;
      pow_e[0] = 64'd1 << 32;
      for (int i = 1; i <= TAB_MID; i++) begin
         pow_e[i] = (pow_e[i-1] * GROWTH_Q20 + (64'd1 << 19)) >> 20;
      end
      for (int k = 0; k < TAB_DEPTH; k++) begin
         m = (k >= TAB_MID) ? k - TAB_MID : TAB_MID - k;
         e = pow_e[m];
         den = e + (64'd1 << 32);
         num = (k >= TAB_MID) ? (e << 16) : (64'd1 << 48);
         p = (num + den / 2) / den;
         logistic_lut[k] = (p > 64'd65535) ? 16'hFFFF : p[15:0];
      end
   endfunction

   function automatic int anc_at(int r, int c);
      return int'(anc_bits[r * PERSONS + c]);
   endfunction

   // probability that the variable under the cursor comes out true
   function automatic logic [PROB_W-1:0] flip_prob();
      int r, c, delta_sat, d;
      r = cur_row;
      c = cur_col;
      delta_sat = 0;
      for (int b = 0; b < PERSONS; b++) begin
         if (b != r && b != c) begin
            delta_sat += anc_at(r, b) & anc_at(b, c);
            delta_sat -= anc_at(c, b) & (anc_at(r, b) ^ 1);
            delta_sat -= anc_at(b, r) & (anc_at(b, c) ^ 1);
         end
      end
      d = int'(cfg_w_trans) * delta_sat;
      if (cfg_parent[r * PERSONS + c]) d += int'(cfg_w_parent);
      if (d > 2047) d = 2047;
      if (d < -2048) d = -2048;
      return logistic_lut[(d + 2048) >> 4];
   endfunction

   function automatic void predict_sample(logic [RAND_W-1:0] word);
      sample_type s;
      int idx;
      logic [PROB_W-1:0] p;
      p = flip_prob();
      idx = cur_row * PERSONS + cur_col;
      s.row = ROW_W'(cur_row);
      s.col = ROW_W'(cur_col);
      s.new_bit = (word < p);
      s.sweep_end = 1'b0;
      s.active = (sweeps_done >= cfg_burn_in);
      anc_bits[idx] = s.new_bit;
      if (s.new_bit) ones_sampled++;
      if (s.active && s.new_bit && tallies[idx] != '1) begin
         tallies[idx]++;
         tally_bumps++;
      end
      s.tally = tallies[idx];
      cur_col++;
      if (cur_col == cur_row) cur_col++;
      if (cur_col >= PERSONS) begin
         cur_row++;
         cur_col = 0;
         if (cur_row >= PERSONS) begin
            cur_row = 0;
            cur_col = 1;
            s.sweep_end = 1'b1;
            sweeps_ended++;
            if (sweeps_done != '1) sweeps_done++;
         end
      end
      pending_samples.push_back(s);
   endfunction

   function automatic logic [DATA_W-1:0] shadow_value(logic [1:0] idx);
      case (idx)
         REG_PARENT_BITS:    return DATA_W'(cfg_parent);
         REG_WEIGHT_PARENT:  return DATA_W'(cfg_w_parent);
         REG_WEIGHT_TRANS:   return DATA_W'(cfg_w_trans);
         REG_BURN_IN_SWEEPS: return DATA_W'(cfg_burn_in);
         default:            return '0;
      endcase
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
      end
   endtask

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) note_mismatch(what, want, got);
   endtask

   stall_mode_type stall_mode = STALL_NONE;
   int stall_left = 0;
   int stall_cyc = 0;

   always @(posedge clock) begin
      sample_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         samples_checked++;
         if (pending_samples.size() == 0) begin
            note_mismatch("unexpected sample beat", 0, 1);
         end else begin
            want = pending_samples.pop_front();
            check_field("var_row", want.row, rsp_var_row);
            check_field("var_col", want.col, rsp_var_col);
            check_field("new_value", want.new_bit, rsp_new_value);
            check_field("end_of_sweep", want.sweep_end, rsp_end_of_sweep);
            check_field("sampling_active", want.active, rsp_sampling_active);
            check_field("tally", want.tally, rsp_tally);
         end
      end
      // receiver back-pressure, switching between stall patterns
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            stall_left = $urandom_range(10, 150);
         end else begin
            stall_left--;
         end
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= ((stall_cyc % 7) < 3);
         endcase
         stall_cyc++;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("testbench: FAIL");
               $finish;
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic send_word(input logic [RAND_W-1:0] word);
      req_valid <= 1'b1;
      req_rand_value <= word;
      do @(posedge clock); while (req_stall);
      predict_sample(word);
      words_sent++;
   endtask

   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // stop sending and wait until every expected sample is back
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      reg_writes++;
      case (idx)
         REG_PARENT_BITS:    cfg_parent = data[PARENT_W-1:0];
         REG_WEIGHT_PARENT:  cfg_w_parent = data[WEIGHT_W-1:0];
         REG_WEIGHT_TRANS:   cfg_w_trans = data[WEIGHT_W-1:0];
         REG_BURN_IN_SWEEPS: cfg_burn_in = data[SWEEP_W-1:0];
         default: ;
      endcase
   endtask

   task automatic read_reg(input logic [1:0] idx);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      check_field("register readback", shadow_value(idx), prdata);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [PARENT_W-1:0] parent,
                                input logic [WEIGHT_W-1:0] w_parent,
                                input logic [WEIGHT_W-1:0] w_trans,
                                input logic [SWEEP_W-1:0] burn_in);
      settle();
      write_reg(REG_PARENT_BITS, DATA_W'(parent));
      write_reg(REG_WEIGHT_PARENT, DATA_W'(w_parent));
      write_reg(REG_WEIGHT_TRANS, DATA_W'(w_trans));
      write_reg(REG_BURN_IN_SWEEPS, DATA_W'(burn_in));
      for (int i = 0; i < 4; i++) read_reg(2'(i));
   endtask

   // random word, often placed right at the decision threshold
   function automatic logic [RAND_W-1:0] pick_word();
      int p;
      case ($urandom_range(0, 5))
         2, 3: begin
            p = int'(flip_prob()) + $urandom_range(0, 5) - 3;
            if (p < 0) p = 0;
            if (p > 65535) p = 65535;
            return RAND_W'(p);
         end
         4: return $urandom_range(0, 1) ? RAND_W'($urandom_range(0, 15))
                                        : RAND_W'(65535 - $urandom_range(0, 15));
         default: return RAND_W'($urandom);
      endcase
   endfunction

   task automatic test_register_defaults();
      for (int i = 0; i < 4; i++) read_reg(2'(i));
   endtask

   task automatic test_register_access();
      for (int i = 0; i < 4; i++) begin
         write_reg(2'(i), '0);
         read_reg(2'(i));
         write_reg(2'(i), '1);
         read_reg(2'(i));
         write_reg(2'(i), $urandom);
         read_reg(2'(i));
      end
   endtask

   task automatic test_directed_words();
      // strong evidence: clamped high, all-ones word must still sample zero
      apply_setting('1, '1, '1, '0);
      send_word(16'h0000);
      send_word(16'hFFFF);
      repeat (4) send_word(16'h0000);
      // zero weights give even odds, straddle the midpoint
      apply_setting('0, '0, '0, '1);
      repeat (3) begin
         send_word(16'h7FFF);
         send_word(16'h8000);
      end
      // transitivity only, pushes toward the clamped low end
      apply_setting('0, '0, '1, '0);
      repeat (4) begin
         send_word(flip_prob() - 16'd1);
         send_word(flip_prob());
      end
   endtask

   task automatic run_random_phase(input int count);
      int sent, burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 48);
         for (int i = 0; i < burst && sent < count; i++) begin
            send_word(pick_word());
            sent++;
         end
         if ($urandom_range(0, 15) == 0) settle();
         else hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
      end
   endtask

   task automatic test_random_phases();
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: apply_setting(PARENT_RESET, WPARENT_RESET, WTRANS_RESET, 16'd2);
            1: apply_setting('1, '1, '1, '0);
            2: apply_setting('0, '0, '0, 16'd1);
            3: apply_setting('0, '0, '1, '1);
            default: apply_setting(PARENT_W'($urandom),
                                   WEIGHT_W'($urandom_range(0, 1) ? $urandom_range(0, 300)
                                                                  : $urandom_range(0, 4095)),
                                   WEIGHT_W'($urandom_range(0, 1) ? $urandom_range(0, 300)
                                                                  : $urandom_range(0, 4095)),
                                   SWEEP_W'($urandom_range(0, 30)));
         endcase
         run_random_phase(PHASE_WORDS);
      end
   endtask

   initial begin
      build_logistic_lut();
      anc_bits = '0;
      cur_row = 0;
      cur_col = 1;
      sweeps_done = '0;
      for (int i = 0; i < NVARS; i++) tallies[i] = '0;
      cfg_parent = PARENT_RESET;
      cfg_w_parent = WPARENT_RESET;
      cfg_w_trans = WTRANS_RESET;
      cfg_burn_in = BURN_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_defaults();
      test_register_access();
      test_directed_words();
      test_random_phases();
      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("testbench: %0d random words sent, %0d samples checked, %0d came out true",
               words_sent, samples_checked, ones_sampled);
      $display("testbench: %0d tally increments over %0d sweeps, %0d register writes",
               tally_bumps, sweeps_ended, reg_writes);
      if (mismatch_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/mgs_pkg.sv
rtl/core/mgs_ram.sv
rtl/core/mgs_logistic.sv
rtl/core/mgs_energy.sv
rtl/core/mln_gibbs_sampler_unit.sv
test/testbench.sv
